// ===== src/sample_zone_selector_unit_assert.svh =====
// Assertion macros shared by the sample zone selector RTL.
`ifndef SAMPLE_ZONE_SELECTOR_UNIT_ASSERT_SVH
`define SAMPLE_ZONE_SELECTOR_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define SZS_ASSERT_NOW(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("szs check failed: label");

// Next-cycle implication, disabled while reset is high.
`define SZS_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("szs check failed: label");

`endif

// ===== src/szs_pkg.sv =====
// Package: types, constants and scoring helpers for the sample zone selector.
`timescale 1ns / 1ps

package szs_pkg;

   localparam int MAX_ZONES_DEFAULT = 64;

   // item opcodes
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   // register indexes (paddr[2])
   localparam logic REG_INSTRUMENT_KIND = 1'b0;
   localparam logic REG_ZONE_COUNT      = 1'b1;

   // instrument kinds
   localparam logic [1:0] KIND_OTHER  = 2'd0;
   localparam logic [1:0] KIND_GUITAR = 2'd1;
   localparam logic [1:0] KIND_BASS   = 2'd2;
   localparam logic [1:0] KIND_PIANO  = 2'd3;

   // penalties in half-semitone units
   localparam logic [8:0] GUITAR_SHARP_PENALTY    = 9'd5;
   localparam logic [8:0] GUITAR_REGISTER_PENALTY = 9'd10;
   localparam logic [8:0] BASS_FLAT_PENALTY       = 9'd3;
   localparam logic [8:0] BASS_STRETCH_PENALTY    = 9'd20;
   localparam logic [8:0] PIANO_STRETCH_PENALTY   = 9'd10;
   localparam logic [6:0] GUITAR_REGISTER_NOTE    = 7'd59;
   localparam logic [6:0] BASS_STRETCH_LIMIT      = 7'd12;
   localparam logic [6:0] PIANO_STRETCH_LIMIT     = 7'd7;
   localparam logic signed [3:0] GUITAR_LAST_STRING = 4'sd5;

   typedef struct packed {
      logic              op;
      logic [5:0]        zone_slot;
      logic [6:0]        zone_root;
      logic [6:0]        zone_low_velocity;
      logic [6:0]        zone_high_velocity;
      logic [6:0]        pitch;
      logic [6:0]        velocity;
      logic signed [3:0] string_number;
      logic [6:0]        anchor_key;
   } req_payload_type;

   typedef struct packed {
      logic       found;
      logic [5:0] chosen_slot;
      logic [8:0] chosen_score;
   } rsp_payload_type;

   typedef struct packed {
      logic [6:0] root;
      logic [6:0] low_velocity;
      logic [6:0] high_velocity;
   } zone_entry_type;

   // query context held for the length of a scan
   typedef struct packed {
      logic [1:0] kind;
      logic [6:0] pitch;
      logic [6:0] velocity;
      logic [6:0] anchor;
      logic       string_ok;
      logic [6:0] string_note;
   } query_ctx_type;

   typedef struct packed {
      logic clear;   // start of a query: drop all running winners
      logic sample;  // memory read data is valid this cycle
   } eval_ctrl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH
   } seq_state_type;

   function automatic logic [6:0] open_string_note(input logic [2:0] idx);
      logic [6:0] note;
      case (idx)
         3'd0: note = 7'd40;
         3'd1: note = 7'd45;
         3'd2: note = 7'd50;
         3'd3: note = 7'd55;
         3'd4: note = 7'd59;
         3'd5: note = 7'd64;
         default: note = 7'd0;
      endcase
      return note;
   endfunction

   function automatic logic [8:0] zone_score(input logic [1:0] kind,
                                             input logic [6:0] pitch,
                                             input logic [6:0] root);
      logic [6:0] semis;
      logic [8:0] score;
      semis = (pitch >= root) ? (pitch - root) : (root - pitch);
      score = {1'b0, semis, 1'b0};
      case (kind)
         KIND_GUITAR: begin
            if (pitch < root)
               score = score + GUITAR_SHARP_PENALTY;
            if (pitch < GUITAR_REGISTER_NOTE && root >= GUITAR_REGISTER_NOTE)
               score = score + GUITAR_REGISTER_PENALTY;
         end
         KIND_BASS: begin
            if (pitch > root)
               score = score + BASS_FLAT_PENALTY;
            if (semis > BASS_STRETCH_LIMIT)
               score = score + BASS_STRETCH_PENALTY;
         end
         KIND_PIANO: begin
            if (semis > PIANO_STRETCH_LIMIT)
               score = score + PIANO_STRETCH_PENALTY;
         end
         default: begin
         end
      endcase
      return score;
   endfunction

endpackage

// ===== src/szs_zone_mem.sv =====
// Zone table: single-port-write, registered-read synchronous memory.
`timescale 1ns / 1ps

module szs_zone_mem #(
   parameter int MAX_ZONES = 64,
   localparam int AW = (MAX_ZONES > 1) ? $clog2(MAX_ZONES) : 1
) (
   input  logic                    clock,
   input  logic                    wr_en,
   input  logic [AW-1:0]           wr_addr,
   input  szs_pkg::zone_entry_type wr_data,
   input  logic [AW-1:0]           rd_addr,
   output szs_pkg::zone_entry_type rd_data
);
   import szs_pkg::*;

   zone_entry_type mem_array [MAX_ZONES];
   zone_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en)
         mem_array[wr_addr] <= wr_data;
      rd_data_ff <= mem_array[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/szs_zone_eval.sv =====
// Per-zone scoring and running winners (anchor, open string, best score).
`timescale 1ns / 1ps

module szs_zone_eval #(
   parameter int MAX_ZONES = 64,
   localparam int AW = (MAX_ZONES > 1) ? $clog2(MAX_ZONES) : 1
) (
   input  logic                    clock,
   input  logic                    reset,
   input  szs_pkg::eval_ctrl_type  ctrl,
   input  logic [AW-1:0]           slot,
   input  szs_pkg::query_ctx_type  ctx,
   input  szs_pkg::zone_entry_type entry,
   output szs_pkg::rsp_payload_type result
);
   import szs_pkg::*;

   logic          anc_hit_ff, anc_hit_in;
   logic [AW-1:0] anc_slot_ff, anc_slot_in;
   logic          str_hit_ff, str_hit_in;
   logic [AW-1:0] str_slot_ff, str_slot_in;
   logic          have_ff, have_in;
   logic [AW-1:0] best_slot_ff, best_slot_in;
   logic [8:0]    best_score_ff, best_score_in;

   logic       eligible;
   logic [8:0] score;

   assign eligible = (ctx.velocity >= entry.low_velocity) &&
                     (ctx.velocity <= entry.high_velocity);
   assign score    = zone_score(ctx.kind, ctx.pitch, entry.root);

   always_comb begin
      anc_hit_in    = anc_hit_ff;
      anc_slot_in   = anc_slot_ff;
      str_hit_in    = str_hit_ff;
      str_slot_in   = str_slot_ff;
      have_in       = have_ff;
      best_slot_in  = best_slot_ff;
      best_score_in = best_score_ff;
      if (ctrl.clear) begin
         anc_hit_in = 1'b0;
         str_hit_in = 1'b0;
         have_in    = 1'b0;
      end else if (ctrl.sample && eligible) begin
         // first match wins for anchor and open string
         if (!anc_hit_ff && ctx.anchor != 7'd0 && entry.root == ctx.anchor) begin
            anc_hit_in  = 1'b1;
            anc_slot_in = slot;
         end
         if (!str_hit_ff && ctx.string_ok && entry.root == ctx.string_note) begin
            str_hit_in  = 1'b1;
            str_slot_in = slot;
         end
         // strict less-than keeps the earlier slot on ties
         if (!have_ff || score < best_score_ff) begin
            have_in       = 1'b1;
            best_slot_in  = slot;
            best_score_in = score;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         anc_hit_ff <= 1'b0;
         str_hit_ff <= 1'b0;
         have_ff    <= 1'b0;
      end else begin
         anc_hit_ff <= anc_hit_in;
         str_hit_ff <= str_hit_in;
         have_ff    <= have_in;
      end
   end

   always_ff @(posedge clock) begin
      anc_slot_ff   <= anc_slot_in;
      str_slot_ff   <= str_slot_in;
      best_slot_ff  <= best_slot_in;
      best_score_ff <= best_score_in;
   end

   always_comb begin
      if (anc_hit_ff)
         result = '{found: 1'b1, chosen_slot: 6'(anc_slot_ff), chosen_score: 9'd0};
      else if (str_hit_ff)
         result = '{found: 1'b1, chosen_slot: 6'(str_slot_ff), chosen_score: 9'd0};
      else if (have_ff)
         result = '{found: 1'b1, chosen_slot: 6'(best_slot_ff),
                    chosen_score: best_score_ff};
      else
         result = '{found: 1'b0, chosen_slot: 6'd0, chosen_score: 9'd0};
   end

endmodule

// ===== src/sample_zone_selector_unit.sv =====
// Sample zone selector: sampler key map with a zone table and a scanning scorer.
//
// Usage
//   req channel (req_valid / req_stall / req_data): one transfer per item.
//     op = write stores root and velocity window in zone_slot; no result.
//     op = query scans the zone table and produces exactly one rsp transfer.
//   rsp channel (rsp_valid / rsp_stall / rsp_data): found, chosen_slot and
//     chosen_score, held in an output register until taken.
//   APB port: register 0 at address 0 is instrument_kind, register 1 at
//     address 4 is zone_count; writes only while the block is idle.
// Sequence
//   A write is stored while the block stays idle; the next item can follow
//   immediately. A query with n = min(zone_count, MAX_ZONES) zones reads
//   one zone per cycle from the single table read port (ST_SCAN), lets the
//   last read land (ST_DRAIN), then loads the output register once it is
//   free (ST_FINISH) and raises rsp_valid; n = 0 goes straight to ST_FINISH.
//   req_stall stays high until the load, so the next item waits for it.
// Reset clears control state and both registers; the zone table is not
//   cleared and must be written before it is queried.
// A stalled result holds rsp_data; a finished scan waits for the output
//   register to free up, and new items are held off meanwhile.
`timescale 1ns / 1ps

module sample_zone_selector_unit #(
   parameter int MAX_ZONES = szs_pkg::MAX_ZONES_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   // request channel
   input  logic                     req_valid,
   output logic                     req_stall,
   input  szs_pkg::req_payload_type req_data,
   // result channel
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output szs_pkg::rsp_payload_type rsp_data,
   // configuration port
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [2:0]               paddr,
   input  logic [31:0]              pwdata,
   output logic [31:0]              prdata,
   output logic                     pready
);
   import szs_pkg::*;

   `include "sample_zone_selector_unit_assert.svh"

   localparam int AW = (MAX_ZONES > 1) ? $clog2(MAX_ZONES) : 1;
   // wide enough for both zone_count and MAX_ZONES itself
   localparam int NW = ($clog2(MAX_ZONES + 1) > 7) ? $clog2(MAX_ZONES + 1) : 7;
   localparam int SW = ($clog2(MAX_ZONES + 1) > 6) ? $clog2(MAX_ZONES + 1) : 6;

   // ---------------------------------------------------------------------
   // configuration registers
   // ---------------------------------------------------------------------
   logic [1:0] kind_ff;
   logic [6:0] count_ff;
   logic       cfg_write;

   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff  <= KIND_OTHER;
         count_ff <= 7'd0;
      end else if (cfg_write) begin
         case (paddr[2])
            REG_INSTRUMENT_KIND: kind_ff  <= pwdata[1:0];
            REG_ZONE_COUNT:      count_ff <= pwdata[6:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         REG_INSTRUMENT_KIND: prdata = 32'(kind_ff);
         REG_ZONE_COUNT:      prdata = 32'(count_ff);
         default:             prdata = 32'd0;
      endcase
   end

   // ---------------------------------------------------------------------
   // sequencer
   // ---------------------------------------------------------------------
   seq_state_type   state_ff, state_in;
   logic [AW-1:0]   idx_ff, idx_in;
   logic [AW-1:0]   last_ff, last_in;
   query_ctx_type   ctx_ff, ctx_in;
   logic            sample_ff, sample_in;
   logic [AW-1:0]   sample_slot_ff;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff;
   logic            rsp_load;

   logic            req_take;
   logic            mem_we;
   logic [NW-1:0]   zone_total;
   logic            string_ok;
   eval_ctrl_type   eval_ctrl;
   zone_entry_type  mem_rdata;
   zone_entry_type  mem_wdata;
   rsp_payload_type eval_result;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;

   // writes beyond the table are dropped
   assign mem_we = req_take && (req_data.op == OP_WRITE) &&
                   (SW'(req_data.zone_slot) < SW'(MAX_ZONES));
   assign mem_wdata = '{root:          req_data.zone_root,
                        low_velocity:  req_data.zone_low_velocity,
                        high_velocity: req_data.zone_high_velocity};

   assign zone_total = (NW'(count_ff) > NW'(MAX_ZONES)) ? NW'(MAX_ZONES)
                                                         : NW'(count_ff);
   assign string_ok  = (kind_ff == KIND_GUITAR) && !req_data.string_number[3] &&
                       (req_data.string_number <= GUITAR_LAST_STRING);

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      last_in      = last_ff;
      ctx_in       = ctx_ff;
      sample_in    = 1'b0;
      rsp_load     = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      eval_ctrl    = '{clear: 1'b0, sample: sample_ff};
      case (state_ff)
         ST_IDLE: begin
            if (req_take && req_data.op == OP_QUERY) begin
               eval_ctrl.clear = 1'b1;
               idx_in          = '0;
               last_in         = AW'(zone_total - NW'(1));
               ctx_in          = '{kind:        kind_ff,
                                   pitch:       req_data.pitch,
                                   velocity:    req_data.velocity,
                                   anchor:      req_data.anchor_key,
                                   string_ok:   string_ok,
                                   string_note: open_string_note(
                                                   req_data.string_number[2:0])};
               state_in        = (zone_total == '0) ? ST_FINISH : ST_SCAN;
            end
         end
         ST_SCAN: begin
            // address idx_ff goes to the memory; its data is scored next cycle
            sample_in = 1'b1;
            if (idx_ff == last_ff)
               state_in = ST_DRAIN;
            else
               idx_in = idx_ff + AW'(1);
         end
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sample_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sample_ff    <= sample_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff         <= idx_in;
      last_ff        <= last_in;
      ctx_ff         <= ctx_in;
      sample_slot_ff <= idx_ff;
      if (rsp_load)
         rsp_data_ff <= eval_result;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ---------------------------------------------------------------------
   // zone table and scorer
   // ---------------------------------------------------------------------
   szs_zone_mem #(
      .MAX_ZONES (MAX_ZONES)
   ) u_zone_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (AW'(req_data.zone_slot)),
      .wr_data (mem_wdata),
      .rd_addr (idx_ff),
      .rd_data (mem_rdata)
   );

   szs_zone_eval #(
      .MAX_ZONES (MAX_ZONES)
   ) u_zone_eval (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (eval_ctrl),
      .slot   (sample_slot_ff),
      .ctx    (ctx_ff),
      .entry  (mem_rdata),
      .result (eval_result)
   );

   // ---------------------------------------------------------------------
   // checks
   // ---------------------------------------------------------------------
   `SZS_ASSERT_NOW(a_empty_result_zero, clock, reset,
      rsp_valid && !rsp_data.found,
      rsp_data.chosen_slot == 6'd0 && rsp_data.chosen_score == 9'd0)
   `SZS_ASSERT_NEXT(a_query_goes_busy, clock, reset,
      req_valid && !req_stall && req_data.op == OP_QUERY,
      req_stall)
   `SZS_ASSERT_NOW(a_write_only_idle, clock, reset,
      mem_we, state_ff == ST_IDLE && !sample_ff)
   `SZS_ASSERT_NEXT(a_load_makes_valid, clock, reset,
      state_ff == ST_FINISH && (!rsp_valid || !rsp_stall),
      rsp_valid && state_ff == ST_IDLE)

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the sample zone selector unit.
`timescale 1ns / 1ps

module testbench;
   import szs_pkg::*;

   localparam int ZONE_SLOTS    = 64;
   localparam int RESET_CYCLES  = 4;
   localparam int SETTLE_CYCLES = 100;   // outlasts the longest scan, 64 zones
   localparam int LONG_HOLD     = 300;   // receiver hold-off in the pressure phase
   localparam int STALL_LIMIT   = 4000;  // cycles without any transfer
   localparam int PHASES        = 8;
   localparam int PHASE_ITEMS   = 40;

   // Every block input has a known value from time zero.
   logic            clock     = 1'b0;
   logic            reset     = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_stall;
   req_payload_type req_data  = '0;
   logic            rsp_valid;
   logic            rsp_stall = 1'b0;
   rsp_payload_type rsp_data;
   logic            psel      = 1'b0;
   logic            penable   = 1'b0;
   logic            pwrite    = 1'b0;
   logic [2:0]      paddr     = 3'd0;
   logic [31:0]     pwdata    = 32'd0;
   logic [31:0]     prdata;
   logic            pready;

   sample_zone_selector_unit #(.MAX_ZONES(ZONE_SLOTS)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   // 2 ns period
   always begin
      #1 clock = 1'b1;
      #1 clock = 0;
   end

   // ------------------------------------------------------------------
   // Shadow of the block: register copies and zone table copy. The table
   // copy is updated when a write item transfers, so predictions follow
   // the exact order in which the block sees the items.
   // ------------------------------------------------------------------
   logic [1:0] cfg_kind  = KIND_OTHER;
   logic [6:0] cfg_count = 7'd0;
   bit   [6:0] zone_root_m [ZONE_SLOTS];
   bit   [6:0] zone_lo_m   [ZONE_SLOTS];
   bit   [6:0] zone_hi_m   [ZONE_SLOTS];
   int         open_note   [0:5] = '{40, 45, 50, 55, 59, 64};
   int         count_plan  [0:PHASES-1] = '{64, 127, 1, 0, 65, 40, 64, 100};

   req_payload_type pending_items  [$];   // items not yet offered
   rsp_payload_type expected_picks [$];   // predicted results, oldest first

   bit offering     = 1'b0;   // an item sits on req_data awaiting transfer
   bit req_fired    = 1'b0;   // req transfer seen at the last rising edge
   bit send_quiet   = 1'b0;   // sender offers back to back
   bit recv_quiet   = 1'b0;   // receiver never stalls
   bit hold_request = 1'b0;   // asks the receiver for one long hold-off
   int send_gap     = 0;
   int stall_left   = 0;
   int hold_left    = 0;
   int idle_cycles  = 0;
   int failures     = 0;
   int queries_checked = 0;
   int writes_taken    = 0;
   int settings_made   = 0;

   // Best zone for a query against the shadow table and registers.
   function automatic rsp_payload_type pick_zone(req_payload_type q);
      rsp_payload_type pick;
      int  scan_len, i, root, pitch_v, semis, score, best_score, string_idx, string_note;
      bit  have;
      pick       = '0;
      have       = 1'b0;
      best_score = 0;
      pitch_v    = q.pitch;
      scan_len   = (cfg_count > ZONE_SLOTS) ? ZONE_SLOTS : cfg_count;

      // anchor: first eligible zone rooted on the anchor key, score 0
      if (q.anchor_key != 7'd0) begin
         for (i = 0; i < scan_len; i++) begin
            if (zone_root_m[i] == q.anchor_key &&
                q.velocity >= zone_lo_m[i] && q.velocity <= zone_hi_m[i]) begin
               pick.found       = 1'b1;
               pick.chosen_slot = i[5:0];
               return pick;
            end
         end
      end

      // open-string note for guitar; -1 never matches a root
      string_idx  = $signed(q.string_number);
      string_note = -1;
      if (cfg_kind == KIND_GUITAR && string_idx >= 0 && string_idx <= 5)
         string_note = open_note[string_idx];

      for (i = 0; i < scan_len; i++) begin
         if (q.velocity >= zone_lo_m[i] && q.velocity <= zone_hi_m[i]) begin
            root = zone_root_m[i];
            if (root == string_note) begin
               pick.found       = 1'b1;
               pick.chosen_slot = i[5:0];
               return pick;
            end
            semis = (pitch_v >= root) ? pitch_v - root : root - pitch_v;
            score = 2 * semis;
            case (cfg_kind)
               KIND_GUITAR: begin
                  if (pitch_v < root)
                     score += int'(GUITAR_SHARP_PENALTY);
                  if (pitch_v < int'(GUITAR_REGISTER_NOTE) && root >= int'(GUITAR_REGISTER_NOTE))
                     score += int'(GUITAR_REGISTER_PENALTY);
               end
               KIND_BASS: begin
                  if (pitch_v > root)
                     score += int'(BASS_FLAT_PENALTY);
                  if (semis > int'(BASS_STRETCH_LIMIT))
                     score += int'(BASS_STRETCH_PENALTY);
               end
               KIND_PIANO: begin
                  if (semis > int'(PIANO_STRETCH_LIMIT))
                     score += int'(PIANO_STRETCH_PENALTY);
               end
               default: begin
               end
            endcase
            // strict compare keeps the earliest slot on ties
            if (!have || score < best_score) begin
               have             = 1'b1;
               best_score       = score;
               pick.chosen_slot = i[5:0];
            end
         end
      end
      pick.found        = have;
      pick.chosen_score = best_score[8:0];
      return pick;
   endfunction

   // ------------------------------------------------------------------
   // Item builders. Unused fields carry random noise so every input bit
   // toggles without affecting the result.
   // ------------------------------------------------------------------
   function automatic req_payload_type noise_item();
      logic [63:0] raw;
      raw = {$urandom, $urandom};
      return raw[$bits(req_payload_type)-1:0];
   endfunction

   function automatic req_payload_type zone_write(int slot, int root, int lo, int hi);
      req_payload_type w;
      w                    = noise_item();
      w.op                 = OP_WRITE;
      w.zone_slot          = slot[5:0];
      w.zone_root          = root[6:0];
      w.zone_low_velocity  = lo[6:0];
      w.zone_high_velocity = hi[6:0];
      return w;
   endfunction

   function automatic req_payload_type zone_query(int pitch, int vel, int str, int anchor);
      req_payload_type q;
      q               = noise_item();
      q.op            = OP_QUERY;
      q.pitch         = pitch[6:0];
      q.velocity      = vel[6:0];
      q.string_number = str[3:0];
      q.anchor_key    = anchor[6:0];
      return q;
   endfunction

   // Roots cluster around the open-string notes so string matches,
   // anchors and near-ties come up often.
   function automatic req_payload_type random_write(int slot);
      int root, lo, hi, roll;
      roll = $urandom_range(0, 99);
      if (roll < 45)
         root = open_note[$urandom_range(0, 5)] + int'($urandom_range(0, 4)) - 2;
      else
         root = $urandom_range(0, 127);
      roll = $urandom_range(0, 99);
      if (roll < 15) begin
         lo = 0;
         hi = 127;
      end else if (roll < 85) begin
         lo = $urandom_range(0, 127);
         hi = $urandom_range(lo, 127);
      end else begin
         lo = $urandom_range(0, 127);   // may come out inverted
         hi = $urandom_range(0, 127);
      end
      return zone_write(slot, root, lo, hi);
   endfunction

   function automatic req_payload_type random_query();
      int roll, pitch, vel, str, anchor;
      roll = $urandom_range(0, 99);
      if (roll < 45)
         anchor = 0;
      else if (roll < 80)
         anchor = zone_root_m[$urandom_range(0, ZONE_SLOTS - 1)];
      else
         anchor = $urandom_range(1, 127);
      roll = $urandom_range(0, 99);
      if (roll < 10)
         vel = 0;
      else if (roll < 20)
         vel = 127;
      else
         vel = $urandom_range(0, 127);
      if ($urandom_range(0, 2) == 0)
         pitch = open_note[$urandom_range(0, 5)] + int'($urandom_range(0, 6)) - 3;
      else
         pitch = $urandom_range(0, 127);
      if ($urandom_range(0, 1) == 0)
         str = $urandom_range(0, 5);
      else
         str = $urandom_range(0, 15);
      return zone_query(pitch, vel, str, anchor);
   endfunction

   // Mostly short gaps, now and then a long one.
   function automatic int pick_gap(bit quiet);
      int roll;
      if (quiet)
         return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55)
         return 0;
      if (roll < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // ------------------------------------------------------------------
   // Request driver: changes req_valid/req_data on the falling edge.
   // req_valid is assigned once per edge; a held item keeps its payload.
   // ------------------------------------------------------------------
   always @(negedge clock) begin
      if (!reset) begin
         if (offering && req_fired)
            offering = 1'b0;
         if (!offering) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (pending_items.size() > 0) begin
               req_data <= pending_items.pop_front();
               offering = 1'b1;
               send_gap = pick_gap(send_quiet);
            end
         end
         req_valid <= offering;
      end
   end

   // ------------------------------------------------------------------
   // Result receiver: random stall bursts, plus one long hold-off on
   // request that lets the block back up into its input channel.
   // ------------------------------------------------------------------
   always @(negedge clock) begin
      if (!reset) begin
         if (hold_request) begin
            hold_left    = LONG_HOLD;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            if (stall_left == 0 && !recv_quiet && $urandom_range(0, 3) == 0)
               stall_left = pick_gap(1'b0);
            rsp_stall <= (stall_left > 0);
            if (stall_left > 0)
               stall_left--;
         end
      end
   end

   // ------------------------------------------------------------------
   // Monitor: sampled at the rising edge. Result transfers are checked
   // against the oldest prediction; request transfers feed the shadow
   // model. The watchdog counts edges with no transfer on either channel.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_fired   = 1'b0;
         idle_cycles = 0;
      end else begin
         req_fired = req_valid && !req_stall;

         if (rsp_valid && !rsp_stall) begin
            if (expected_picks.size() == 0) begin
               $error("result transfer with no query outstanding: found %0d slot %0d score %0d",
                      rsp_data.found, rsp_data.chosen_slot, rsp_data.chosen_score);
               failures++;
            end else begin
               rsp_payload_type want;
               want = expected_picks.pop_front();
               if (rsp_data.found !== want.found) begin
                  $error("found: expected %0d, got %0d", want.found, rsp_data.found);
                  failures++;
               end
               if (rsp_data.chosen_slot !== want.chosen_slot) begin
                  $error("chosen_slot: expected %0d, got %0d",
                         want.chosen_slot, rsp_data.chosen_slot);
                  failures++;
               end
               if (rsp_data.chosen_score !== want.chosen_score) begin
                  $error("chosen_score: expected %0d, got %0d",
                         want.chosen_score, rsp_data.chosen_score);
                  failures++;
               end
               queries_checked++;
            end
         end

         if (req_fired) begin
            if (req_data.op == OP_QUERY) begin
               expected_picks.push_back(pick_zone(req_data));
            end else begin
               zone_root_m[req_data.zone_slot] = req_data.zone_root;
               zone_lo_m[req_data.zone_slot]   = req_data.zone_low_velocity;
               zone_hi_m[req_data.zone_slot]   = req_data.zone_high_velocity;
               writes_taken++;
            end
         end

         if (req_fired || (rsp_valid && !rsp_stall))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------
   // APB access: setup cycle, then access cycle until pready.
   // ------------------------------------------------------------------
   task automatic csr_access(input logic write_en, input logic reg_idx,
                             input logic [31:0] wdata, output logic [31:0] rdata);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= write_en;
      paddr   <= {reg_idx, 2'b00};
      pwdata  <= wdata;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      rdata = prdata;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // Write a register, update the shadow copy and read it back.
   task automatic set_register(input logic reg_idx, input int value);
      logic [31:0] readback, mirror;
      csr_access(1'b1, reg_idx, value, readback);
      if (reg_idx == REG_INSTRUMENT_KIND)
         cfg_kind = value[1:0];
      else
         cfg_count = value[6:0];
      mirror = (reg_idx == REG_INSTRUMENT_KIND) ? 32'(cfg_kind) : 32'(cfg_count);
      csr_access(1'b0, reg_idx, 32'd0, readback);
      if (readback !== mirror) begin
         $error("register %0d readback: expected %0d, got %0d", reg_idx, mirror, readback);
         failures++;
      end
      settings_made++;
   endtask

   // Let everything drain: all items sent, all results back, and then
   // enough cycles for a trailing write to finish inside the block.
   task automatic settle();
      while (pending_items.size() > 0 || offering || expected_picks.size() > 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // ------------------------------------------------------------------
   // Stimulus sequence
   // ------------------------------------------------------------------
   initial begin
      int slot, phase, k;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // Directed part. Registers are at reset: zero zones, so nothing found.
      pending_items.push_back(zone_query(60, 64, -1, 0));
      // Small zone set covering the key corner cases
      pending_items.push_back(zone_write(0, 60, 0, 127));
      pending_items.push_back(zone_write(1, 40, 0, 63));
      pending_items.push_back(zone_write(2, 64, 64, 127));
      pending_items.push_back(zone_write(3, 127, 127, 127));
      pending_items.push_back(zone_write(4, 0, 0, 0));
      pending_items.push_back(zone_write(5, 59, 100, 20));    // inverted window
      pending_items.push_back(zone_write(6, 45, 0, 127));
      pending_items.push_back(zone_write(7, 72, 10, 90));
      settle();

      set_register(REG_INSTRUMENT_KIND, KIND_OTHER);
      set_register(REG_ZONE_COUNT, 8);
      pending_items.push_back(zone_query(0, 0, 0, 0));        // lowest corner
      pending_items.push_back(zone_query(127, 127, 7, 0));    // highest corner
      pending_items.push_back(zone_query(90, 10, -1, 40));    // anchor hit
      pending_items.push_back(zone_query(90, 100, -1, 40));   // anchor out of window
      pending_items.push_back(zone_query(30, 50, -1, 99));    // anchor on no root
      pending_items.push_back(zone_query(62, 80, -1, 0));     // tie, earlier slot wins
      settle();

      set_register(REG_INSTRUMENT_KIND, KIND_GUITAR);
      pending_items.push_back(zone_query(70, 30, 1, 0));      // string match beats earlier
      pending_items.push_back(zone_query(80, 30, 0, 0));      // lowest string
      pending_items.push_back(zone_query(50, 80, -1, 0));     // sharp and register penalty
      pending_items.push_back(zone_query(50, 80, 6, 0));      // string out of range
      pending_items.push_back(zone_query(58, 110, 4, 0));     // open string in bad window
      settle();

      set_register(REG_INSTRUMENT_KIND, KIND_BASS);
      pending_items.push_back(zone_query(30, 80, 2, 0));
      pending_items.push_back(zone_query(100, 5, -8, 0));
      settle();

      set_register(REG_INSTRUMENT_KIND, KIND_PIANO);
      pending_items.push_back(zone_query(68, 50, 3, 0));
      pending_items.push_back(zone_query(55, 70, -1, 0));
      settle();

      // Random part. Fill the whole table first; queries in between only
      // scan the eight slots written above.
      set_register(REG_INSTRUMENT_KIND, $urandom_range(0, 3));
      for (slot = 0; slot < ZONE_SLOTS; slot++) begin
         pending_items.push_back(random_write(slot));
         if ($urandom_range(0, 3) == 0)
            pending_items.push_back(random_query());
      end
      settle();

      // Table is fully written from here on: any zone count is safe,
      // including counts past the table size.
      for (phase = 0; phase < PHASES; phase++) begin
         set_register(REG_INSTRUMENT_KIND, phase % 4);
         set_register(REG_ZONE_COUNT, count_plan[phase]);
         // phase 2 is the back-pressure phase: back-to-back sender,
         // receiver holding off long enough to fill the block
         send_quiet = (phase == 2) || ($urandom_range(0, 4) == 0);
         recv_quiet = (phase != 2) && ($urandom_range(0, 4) == 0);
         if (phase == 2)
            hold_request = 1'b1;
         for (k = 0; k < PHASE_ITEMS; k++) begin
            if ($urandom_range(0, 3) == 0)
               pending_items.push_back(random_write($urandom_range(0, ZONE_SLOTS - 1)));
            else
               pending_items.push_back(random_query());
         end
         settle();
      end

      $display("Run covered %0d zone writes and %0d checked queries", writes_taken,
               queries_checked);
      $display("across %0d register settings over all four instrument kinds", settings_made);
      if (failures == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
